// ===== hdl/iis_pkg.sv =====
// Shared constants, register indexes and the stage record for the integral image stream.
`default_nettype none
package iis_pkg;

  // Frame limits and pixel depth.
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIXEL_BITS = 8;

  // Derived widths.
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 11;
  localparam int ROWSUM_W = 2 * PIXEL_BITS + COL_W;
  localparam int SUM_W    = ROWSUM_W + ROW_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Reset values of the size registers.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_ROWS);

  // One pixel after the scan stage, on its way to the accumulate stage.
  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [ROWSUM_W-1:0] row_sum;
    logic                first_row;
    logic                row_end;
    logic                frame_end;
  } scan_t;

endpackage
`default_nettype wire

// ===== hdl/iis_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module iis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port returns the old contents when both ports hit one entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/iis_scan.sv =====
// Configuration registers, raster position counters and the running row sum.
`default_nettype none
module iis_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [iis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [iis_pkg::DIM_W-1:0]      cfg_data_i,
  input  wire logic [iis_pkg::PIXEL_BITS-1:0] pixel_i,
  input  wire logic                           accept_i,
  output iis_pkg::scan_t                      item_o
);
  import iis_pkg::*;

  logic                  square_mode_q;
  logic [DIM_W-1:0]      frame_width_q;
  logic [DIM_W-1:0]      frame_height_q;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [ROWSUM_W-1:0]   row_sum_q, row_sum_d;
  logic [DIM_W-1:0]      width_eff;
  logic [DIM_W-1:0]      height_eff;
  logic [2*PIXEL_BITS-1:0] pixel_sq;
  logic [ROWSUM_W-1:0]   term;
  logic                  last_col;
  logic                  last_row;

  assign cfg_ready_o = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_mode_q  <= 1'b0;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SQUARE_MODE:  square_mode_q  <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero counts as one, anything above the limit counts as the limit.
  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = DIM_W'(1);
    end else if (frame_width_q > DIM_W'(MAX_COLS)) begin
      width_eff = DIM_W'(MAX_COLS);
    end else begin
      width_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      height_eff = DIM_W'(1);
    end else if (frame_height_q > DIM_W'(MAX_ROWS)) begin
      height_eff = DIM_W'(MAX_ROWS);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // Pixel term and the row sum up to and including this pixel.
  always_comb begin
    pixel_sq  = (2*PIXEL_BITS)'(pixel_i) * (2*PIXEL_BITS)'(pixel_i);
    term      = square_mode_q ? ROWSUM_W'(pixel_sq) : ROWSUM_W'(pixel_i);
    row_sum_d = ((col_q == '0) ? '0 : row_sum_q) + term;
    last_col  = (DIM_W'(col_q) + DIM_W'(1)) >= width_eff;
    last_row  = (DIM_W'(row_q) + DIM_W'(1)) >= height_eff;
  end

  // Next raster position.
  always_comb begin
    col_d = col_q + COL_W'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
    end else if (accept_i) begin
      col_q     <= col_d;
      row_q     <= row_d;
      row_sum_q <= row_sum_d;
    end
  end

  // Record handed to the accumulate stage.
  always_comb begin
    item_o.col       = col_q;
    item_o.row_sum   = row_sum_d;
    item_o.first_row = (row_q == '0);
    item_o.row_end   = last_col;
    item_o.frame_end = last_col & last_row;
  end

endmodule
`default_nettype wire

// ===== hdl/iis_accum.sv =====
// Accumulate stage: adds the line-store value from above, writes it back, holds the result.
`default_nettype none
module iis_accum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  iis_pkg::scan_t                   item_i,
  input  wire logic [iis_pkg::SUM_W-1:0]   rd_data_i,
  output logic                             wr_en_o,
  output logic      [iis_pkg::COL_W-1:0]   wr_addr_o,
  output logic      [iis_pkg::SUM_W-1:0]   wr_data_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [iis_pkg::SUM_W-1:0]   area_sum_o,
  output logic                             row_end_o,
  output logic                             frame_end_o
);
  import iis_pkg::*;

  scan_t             s1_q;
  logic              s1_valid_q;
  logic              s1_fwd_q, s1_fwd_d;
  logic [SUM_W-1:0]  fwd_data_q;
  logic              s1_adv;
  logic              accept;
  logic [SUM_W-1:0]  above;
  logic [SUM_W-1:0]  sum;
  logic              out_valid_q;
  logic [SUM_W-1:0]  area_sum_q;
  logic              row_end_q;
  logic              frame_end_q;

  // Handshake between the stages.
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign accept     = in_valid_i & ~in_stall_o;

  // The entry being written this cycle is the one just read: take the new value.
  assign s1_fwd_d = s1_adv & (item_i.col == s1_q.col);

  // Integral value at this pixel.
  always_comb begin
    if (s1_q.first_row) begin
      above = '0;
    end else if (s1_fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = rd_data_i;
    end
    sum = SUM_W'(s1_q.row_sum) + above;
  end

  assign wr_en_o   = s1_adv;
  assign wr_addr_o = s1_q.col;
  assign wr_data_o = sum;

  // Stage register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fwd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_fwd_q   <= s1_fwd_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        s1_fwd_q   <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      fwd_data_q  <= sum;
      area_sum_q  <= sum;
      row_end_q   <= s1_q.row_end;
      frame_end_q <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_sum_o  = area_sum_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

  // A forwarded value only exists alongside a held pixel.
  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("forward flag set without a pixel in the accumulate stage");

  // A new beat never overwrites a pixel that has not moved on.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!s1_valid_q || s1_adv))
    else $error("accumulate stage overwritten");

  // A pixel that leaves the accumulate stage shows up at the output.
  a_adv_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result lost between stages");

  // The last pixel of a frame is also the last of its row.
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_end_q) |-> row_end_q)
    else $error("frame end without row end");

endmodule
`default_nettype wire

// ===== hdl/integral_image_stream.sv =====
// A pixel beat accepted is registered in the accumulate stage, then in the result register.
// Throughput: one pixel per cycle unless the output stalls; the line store is read for the
// next pixel while the current one is written back, and a same-column hit is forwarded.
// Reset clears the counters, the row sum, the stage flags and the size and mode
// registers; the line store is not cleared, as the first row of a frame never uses it.
// Top level: scan stage, line store and accumulate stage of the integral image stream.
`default_nettype none
module integral_image_stream (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [iis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [iis_pkg::DIM_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [iis_pkg::PIXEL_BITS-1:0] pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [iis_pkg::SUM_W-1:0]      area_sum_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);
  import iis_pkg::*;

  scan_t             item;
  logic              accept;
  logic [SUM_W-1:0]  rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [SUM_W-1:0]  wr_data;

  assign accept = in_valid_i & ~in_stall_o;

  iis_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .accept_i    (accept),
    .item_o      (item)
  );

  // Line store: integral values of the previous row, one entry per column.
  iis_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (item.col),
    .rdata_o (rd_data)
  );

  iis_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .area_sum_o  (area_sum_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming integral image block.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_PIXELS = 1050;
  localparam int unsigned CALM_PIXELS   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;

  // The block ignores this register index.
  localparam logic [iis_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // One expected result beat.
  typedef struct packed {
    logic [iis_pkg::SUM_W-1:0] area_sum;
    logic                      row_end;
    logic                      frame_end;
  } area_beat_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                             cfg_valid = 1'b0;
  logic [iis_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [iis_pkg::DIM_W-1:0]        cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic [iis_pkg::PIXEL_BITS-1:0]   pixel     = '0;
  logic                             out_stall = 1'b0;
  logic                             cfg_ready;
  logic                             in_stall;
  logic                             out_valid;
  logic [iis_pkg::SUM_W-1:0]        area_sum;
  logic                             row_end;
  logic                             frame_end;

  integral_image_stream i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .area_sum_o  (area_sum),
    .row_end_o   (row_end),
    .frame_end_o (frame_end)
  );

  // Shadow copy of the registers and the integration state.
  logic                        sq_mode   = 1'b0;
  logic [iis_pkg::DIM_W-1:0]   width_reg  = iis_pkg::WIDTH_RESET;
  logic [iis_pkg::DIM_W-1:0]   height_reg = iis_pkg::HEIGHT_RESET;
  logic [iis_pkg::SUM_W-1:0]   row_acc   = '0;
  logic [iis_pkg::SUM_W-1:0]   prev_row_sums [iis_pkg::MAX_COLS];
  int unsigned                 col_cnt   = 0;
  int unsigned                 row_cnt   = 0;

  area_beat_t  sat_expect_q [$];
  area_beat_t  head_beat;
  int unsigned mismatches   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned cycle_count  = 0;
  bit          gaps_on      = 1'b1;
  bit          stall_on     = 1'b1;

  // Size registers: zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned eff_dim(input logic [iis_pkg::DIM_W-1:0] v,
                                          input int unsigned max_dim);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  function automatic void apply_reg(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [iis_pkg::DIM_W-1:0] data);
    case (idx)
      iis_pkg::CFG_SQUARE_MODE:  sq_mode = data[0];
      iis_pkg::CFG_FRAME_WIDTH:  width_reg = data;
      iis_pkg::CFG_FRAME_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one pixel and returns its summed-area beat.
  function automatic area_beat_t integrate_pixel(input logic [iis_pkg::PIXEL_BITS-1:0] pix);
    logic [iis_pkg::SUM_W-1:0] term;
    logic [iis_pkg::SUM_W-1:0] above;
    int unsigned w;
    int unsigned h;
    area_beat_t beat;
    w = eff_dim(width_reg, iis_pkg::MAX_COLS);
    h = eff_dim(height_reg, iis_pkg::MAX_ROWS);
    term = iis_pkg::SUM_W'(pix);
    if (sq_mode) term = term * term;
    if (col_cnt == 0) row_acc = '0;
    row_acc = row_acc + term;
    above = (row_cnt != 0) ? prev_row_sums[iis_pkg::COL_W'(col_cnt)] : '0;
    beat.area_sum = row_acc + above;
    prev_row_sums[iis_pkg::COL_W'(col_cnt)] = beat.area_sum;
    beat.row_end = (col_cnt + 1 >= w);
    beat.frame_end = beat.row_end && (row_cnt + 1 >= h);
    if (beat.row_end) begin
      col_cnt = 0;
      row_cnt = beat.frame_end ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return beat;
  endfunction

  // Clock and run limit.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[integral_image_stream] ERROR");
    $finish;
  end

  // Result-side backpressure in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watches all three channels: register writes and pixel beats feed the shadow
  // state, result beats are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sat_expect_q.push_back(integrate_pixel(pixel));
      if (out_valid && !out_stall) begin
        if (sat_expect_q.size() == 0) begin
          $error("result beat with no pixel pending: area_sum %0d", area_sum);
          mismatches++;
        end else begin
          head_beat = sat_expect_q.pop_front();
          if (area_sum !== head_beat.area_sum) begin
            $error("area_sum: expected %0d, got %0d", head_beat.area_sum, area_sum);
            mismatches++;
          end
          if (row_end !== head_beat.row_end) begin
            $error("row_end: expected %0b, got %0b", head_beat.row_end, row_end);
            mismatches++;
          end
          if (frame_end !== head_beat.frame_end) begin
            $error("frame_end: expected %0b, got %0b", head_beat.frame_end, frame_end);
            mismatches++;
          end
        end
      end
    end
  end

  // Sends one pixel beat, sometimes after an idle burst.
  task automatic send_pixel(input logic [iis_pkg::PIXEL_BITS-1:0] pix);
    int unsigned idle_len;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      idle_len = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (idle_len) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Stops the pixel stream until every pending result beat has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sat_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iis_pkg::DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic mode, input logic [iis_pkg::DIM_W-1:0] w,
                           input logic [iis_pkg::DIM_W-1:0] h);
    settle();
    write_reg(iis_pkg::CFG_SQUARE_MODE, iis_pkg::DIM_W'(mode));
    write_reg(iis_pkg::CFG_FRAME_WIDTH, w);
    write_reg(iis_pkg::CFG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_one(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iis_pkg::DIM_W-1:0] data);
    settle();
    write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform pixels with the two extremes mixed in.
  function automatic logic [iis_pkg::PIXEL_BITS-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return iis_pkg::PIXEL_BITS'($urandom);
    endcase
  endfunction

  // Sends pixels up to and including the end of the current frame.
  task automatic finish_frame(input bit all_max);
    int unsigned w;
    int unsigned h;
    int unsigned cols_left;
    int unsigned rows_left;
    int unsigned n;
    settle();
    w = eff_dim(width_reg, iis_pkg::MAX_COLS);
    h = eff_dim(height_reg, iis_pkg::MAX_ROWS);
    cols_left = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
    rows_left = (row_cnt + 1 >= h) ? 0 : h - row_cnt - 1;
    n = cols_left + rows_left * w;
    repeat (n) send_pixel(all_max ? '1 : random_pixel());
  endtask

  // A few pixels under the reset configuration.
  task automatic test_reset_defaults();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);
  endtask

  // Narrowing the row mid-row ends it at once, then extreme and bit-pattern pixels
  // in both modes.
  task automatic test_pixel_extremes();
    configure(1'b0, 11'd3, 11'd2);
    send_pixel(8'd7);
    finish_frame(1'b0);
    configure(1'b1, 11'd3, 11'd2);
    repeat (6) send_pixel(8'd255);
    configure(1'b0, 11'd3, 11'd2);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    send_pixel(8'h01);
    send_pixel(8'h80);
  endtask

  // Register writes in the middle of a frame take effect on the next pixel.
  task automatic test_mid_frame_writes();
    configure(1'b0, 11'd6, 11'd4);
    repeat (9) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_SQUARE_MODE, 11'd1);
    repeat (4) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_WIDTH, 11'd2);
    send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_HEIGHT, 11'd1);
    finish_frame(1'b0);
    // Widening is only done on the first row, where the store is filled as it goes.
    configure(1'b0, 11'd3, 11'd3);
    repeat (2) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_WIDTH, 11'd7);
    repeat (8) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_HEIGHT, 11'd5);
    finish_frame(1'b0);
  endtask

  // A write to the spare index changes nothing.
  task automatic test_unused_index();
    configure(1'b1, 11'd5, 11'd2);
    write_one(CFG_UNUSED_IDX, 11'h7FF);
    finish_frame(1'b0);
  endtask

  // Out-of-range sizes, then a frame of saturated pixels in square mode.
  task automatic test_size_clamps();
    configure(1'b0, 11'd0, 11'd0);
    repeat (3) send_pixel(random_pixel());
    // An oversized width must not end the row early; narrowing then closes it.
    configure(1'b0, 11'd2047, 11'd1);
    repeat (40) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_WIDTH, 11'd2);
    finish_frame(1'b0);
    // An oversized height must not end the frame early; lowering it then closes it.
    configure(1'b1, 11'd1, 11'd2047);
    repeat (20) send_pixel(random_pixel());
    write_one(iis_pkg::CFG_FRAME_HEIGHT, 11'd1);
    finish_frame(1'b0);
    configure(1'b1, 11'd8, 11'd4);
    finish_frame(1'b1);
  endtask

  // Random small frames, some with a register write in the middle.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned new_w;
    goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < goal) begin
      if (goal - pixels_sent < CALM_PIXELS) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      configure(1'($urandom_range(0, 1)), 11'($urandom_range(0, 24)),
                11'($urandom_range(0, 10)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10)) send_pixel(random_pixel());
        settle();
        case ($urandom_range(0, 2))
          0: write_one(iis_pkg::CFG_SQUARE_MODE, 11'(!sq_mode));
          1: write_one(iis_pkg::CFG_FRAME_HEIGHT, 11'($urandom_range(0, 10)));
          default: begin
            // Past the first row the row may only get narrower.
            if (row_cnt == 0) new_w = $urandom_range(0, 24);
            else new_w = $urandom_range(0, eff_dim(width_reg, iis_pkg::MAX_COLS));
            write_one(iis_pkg::CFG_FRAME_WIDTH, 11'(new_w));
          end
        endcase
      end
      finish_frame(1'b0);
    end
  endtask

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_pixel_extremes();
    test_mid_frame_writes();
    test_unused_index();
    test_size_clamps();
    test_random_frames();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[integral_image_stream] OK");
    end else begin
      $display("[integral_image_stream] ERROR");
    end
    $finish;
  end

endmodule

// ===== integral_image_stream.f =====
hdl/iis_pkg.sv
hdl/iis_ram.sv
hdl/iis_scan.sv
hdl/iis_accum.sv
hdl/integral_image_stream.sv
tb/tb.sv
